FILE: design/brs_pkg.sv
// ----------------------------------------------------------------------------
// brs_pkg
// Shared types, codes and saturating fixed-point helpers for the Brent root
// solver.
// ----------------------------------------------------------------------------
package brs_pkg;

  localparam int VALUE_WIDTH   = 32;
  localparam int FRACTION_BITS = 16;
  localparam int CFG_IDX_W     = 2;

  typedef logic signed [VALUE_WIDTH-1:0] val_t;
  typedef logic [VALUE_WIDTH-1:0]        mag_t;
  typedef logic [2*VALUE_WIDTH-1:0]      wide_t;
  typedef logic [VALUE_WIDTH-2:0]        tol_t;
  typedef logic [15:0]                   iter_t;

  localparam val_t VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam val_t VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  localparam logic [1:0] ST_EVAL      = 2'd0;
  localparam logic [1:0] ST_CONVERGED = 2'd1;
  localparam logic [1:0] ST_NO_ROOT   = 2'd2;
  localparam logic [1:0] ST_LIMIT     = 2'd3;

  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_ANSWER = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_TOL     = 2'd3;

  typedef struct packed {
    logic kind;
    val_t reference_level;
    val_t function_value;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    val_t       point;
  } out_t;

  typedef struct packed {
    logic start;
    logic div;
    val_t a;
    val_t b;
  } alu_req_t;

  typedef struct packed {
    logic done;
    val_t y;
  } alu_rsp_t;

  function automatic val_t clamp1(logic signed [VALUE_WIDTH:0] x);
    if (x[VALUE_WIDTH] != x[VALUE_WIDTH-1]) begin
      return x[VALUE_WIDTH] ? VMIN : VMAX;
    end
    return x[VALUE_WIDTH-1:0];
  endfunction

  function automatic val_t sadd(val_t a, val_t b);
    logic signed [VALUE_WIDTH:0] s;
    s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
    return clamp1(s);
  endfunction

  function automatic val_t ssub(val_t a, val_t b);
    logic signed [VALUE_WIDTH:0] s;
    s = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
    return clamp1(s);
  endfunction

  function automatic mag_t mag(val_t a);
    return a[VALUE_WIDTH-1] ? mag_t'(-a) : mag_t'(a);
  endfunction

  function automatic val_t sabs(val_t a);
    mag_t m;
    m = mag(a);
    return m[VALUE_WIDTH-1] ? VMAX : val_t'(m);
  endfunction

  function automatic val_t from_mag(logic neg, wide_t mw);
    wide_t lim;
    lim = wide_t'(VMAX) + wide_t'(neg);
    if (mw > lim) begin
      return neg ? VMIN : VMAX;
    end
    return neg ? val_t'(-mw[VALUE_WIDTH-1:0]) : val_t'(mw[VALUE_WIDTH-1:0]);
  endfunction

  function automatic logic same_sign(val_t x, val_t y);
    return (x > 0 && y > 0) || (x < 0 && y < 0);
  endfunction

endpackage

FILE: design/brent_root_solver_core.sv
// a start item, the low-end answer, a high-end answer of the same sign and a limit answer register
// their result in the cycle after they are taken; a Brent step answer walks the states B1 to B4 and
// then gives the converged result, goes to the update state on bisection, or on interpolation runs
// its divides and multiplies through the shared serial multiply/divide unit; one item at a time
// synchronous rst returns the sequencer to idle, drops the output and loads
// the register defaults
// ----------------------------------------------------------------------------
// brent_root_solver_core
// Brent root finder driving an external function through its result channel;
// a small sequencer steps the update through one shared multiply/divide unit.
// ----------------------------------------------------------------------------
module brent_root_solver_core #(
  parameter int FRAC_BITS = brs_pkg::FRACTION_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  brs_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output brs_pkg::out_t                   out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [brs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  brs_pkg::val_t                   cfg_data
);
  import brs_pkg::*;

  localparam int W = VALUE_WIDTH;
  localparam val_t ONE = (FRAC_BITS >= W - 1) ? VMAX : val_t'(W'(1) << FRAC_BITS);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LOW  = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;
  localparam logic [1:0] PH_STEP = 2'd3;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_B1   = 5'd1;
  localparam logic [4:0] S_B2   = 5'd2;
  localparam logic [4:0] S_B3   = 5'd3;
  localparam logic [4:0] S_B4   = 5'd4;
  localparam logic [4:0] S_D1   = 5'd5;
  localparam logic [4:0] S_M1   = 5'd6;
  localparam logic [4:0] S_Q1   = 5'd7;
  localparam logic [4:0] S_D2   = 5'd8;
  localparam logic [4:0] S_D3   = 5'd9;
  localparam logic [4:0] S_M2   = 5'd10;
  localparam logic [4:0] S_M3   = 5'd11;
  localparam logic [4:0] S_M4   = 5'd12;
  localparam logic [4:0] S_M5   = 5'd13;
  localparam logic [4:0] S_M6   = 5'd14;
  localparam logic [4:0] S_M7   = 5'd15;
  localparam logic [4:0] S_SGN  = 5'd16;
  localparam logic [4:0] S_M8   = 5'd17;
  localparam logic [4:0] S_M9   = 5'd18;
  localparam logic [4:0] S_CMP  = 5'd19;
  localparam logic [4:0] S_D4   = 5'd20;
  localparam logic [4:0] S_UPD  = 5'd21;

  val_t  ilo;
  val_t  ihi;
  iter_t ilim;
  tol_t  vtol;

  logic [1:0] phase;
  logic [4:0] state;
  logic       pend;
  iter_t      iter;
  val_t       tgt;
  val_t       bpt;
  val_t       apt;
  val_t       cpt;
  val_t       fb;
  val_t       fa;
  val_t       fc;
  val_t       dstep;
  val_t       estep;
  logic       coll;
  val_t       m;
  val_t       s;
  val_t       p;
  val_t       q;
  val_t       r;
  val_t       t;
  val_t       u;

  alu_req_t ureq;
  alu_rsp_t ursp;

  logic                  in_fire;
  logic                  is_op;
  val_t                  f;
  logic signed [W:0]     cdiff;
  logic signed [W:0]     hsum;
  val_t                  half;
  val_t                  step_add;
  val_t                  nb;

  brs_alu #(
    .FRAC_BITS(FRAC_BITS)
  ) u_alu (
    .clk(clk),
    .rst(rst),
    .req(ureq),
    .rsp(ursp)
  );

  assign in_stall  = (state != S_IDLE) || out_valid;
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    is_op = state inside {S_D1, S_M1, S_D2, S_D3, S_M2, S_M3, S_M4, S_M5, S_M6,
                          S_M7, S_M8, S_M9, S_D4};
    f     = ssub(in_data.function_value, tgt);
    cdiff = {cpt[W-1], cpt} - {bpt[W-1], bpt};
    hsum  = cdiff + {{W{1'b0}}, cdiff[W]};
    half  = hsum[W:1];
    if (mag(dstep) > mag_t'(1)) begin
      step_add = dstep;
    end else begin
      step_add = (m > 0) ? val_t'(1) : -val_t'(1);
    end
    nb = sadd(bpt, step_add);
  end

  always_comb begin
    ureq.div = 1'b0;
    ureq.a   = fb;
    ureq.b   = fa;
    case (state)
      S_D1: begin
        ureq.div = 1'b1;
      end
      S_M1: begin
        ureq.a = sadd(m, m);
        ureq.b = s;
      end
      S_D2: begin
        ureq.div = 1'b1;
        ureq.a   = fa;
        ureq.b   = fc;
      end
      S_D3: begin
        ureq.div = 1'b1;
        ureq.b   = fc;
      end
      S_M2: begin
        ureq.a = sadd(m, m);
        ureq.b = q;
      end
      S_M3: begin
        ureq.a = t;
        ureq.b = ssub(q, r);
      end
      S_M4: begin
        ureq.a = ssub(bpt, apt);
        ureq.b = ssub(r, ONE);
      end
      S_M5: begin
        ureq.a = s;
        ureq.b = ssub(t, u);
      end
      S_M6: begin
        ureq.a = ssub(q, ONE);
        ureq.b = ssub(r, ONE);
      end
      S_M7: begin
        ureq.a = t;
        ureq.b = ssub(s, ONE);
      end
      S_M8: begin
        ureq.a = sadd(sadd(m, m), m);
        ureq.b = q;
      end
      S_M9: begin
        ureq.a = estep;
        ureq.b = q;
      end
      S_D4: begin
        ureq.div = 1'b1;
        ureq.a   = p;
        ureq.b   = q;
      end
      default: begin
      end
    endcase
    ureq.start = is_op && !pend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ilo       <= '0;
      ihi       <= ONE;
      ilim      <= iter_t'(100);
      vtol      <= '0;
      phase     <= PH_IDLE;
      state     <= S_IDLE;
      pend      <= 1'b0;
      iter      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_INTERVAL_LOW:  ilo  <= cfg_data;
          CFG_INTERVAL_HIGH: ihi  <= cfg_data;
          CFG_ITER_LIMIT:    ilim <= cfg_data[15:0];
          CFG_VALUE_TOL:     vtol <= cfg_data[W-2:0];
          default: begin
          end
        endcase
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (is_op && !pend) begin
        pend <= 1'b1;
      end
      if (ursp.done) begin
        pend <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (in_data.kind == KIND_START) begin
              tgt       <= in_data.reference_level;
              apt       <= ilo;
              bpt       <= ihi;
              phase     <= PH_LOW;
              out_valid <= 1'b1;
              out_data  <= '{status: ST_EVAL, point: ilo};
            end else begin
              case (phase)
                PH_LOW: begin
                  fa        <= f;
                  phase     <= PH_HIGH;
                  out_valid <= 1'b1;
                  out_data  <= '{status: ST_EVAL, point: bpt};
                end
                PH_HIGH: begin
                  fb <= f;
                  if (same_sign(f, fa)) begin
                    phase     <= PH_IDLE;
                    out_valid <= 1'b1;
                    out_data  <= '{status: ST_NO_ROOT, point: ONE};
                  end else begin
                    fc    <= f;
                    cpt   <= '0;
                    dstep <= '0;
                    estep <= '0;
                    coll  <= 1'b0;
                    iter  <= '0;
                    state <= S_B1;
                  end
                end
                PH_STEP: begin
                  fb <= f;
                  if (iter >= ilim) begin
                    phase     <= PH_IDLE;
                    out_valid <= 1'b1;
                    out_data  <= '{status: ST_LIMIT, point: bpt};
                  end else begin
                    iter  <= iter + 1'b1;
                    state <= S_B1;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end
        S_B1: begin
          if (same_sign(fb, fc)) begin
            cpt   <= apt;
            fc    <= fa;
            dstep <= ssub(bpt, apt);
            estep <= ssub(bpt, apt);
          end
          state <= S_B2;
        end
        S_B2: begin
          if (mag(fc) < mag(fb)) begin
            apt <= bpt;
            bpt <= cpt;
            cpt <= bpt;
            fa  <= fb;
            fb  <= fc;
            fc  <= fb;
          end
          state <= S_B3;
        end
        S_B3: begin
          coll  <= apt == cpt;
          m     <= half;
          state <= S_B4;
        end
        S_B4: begin
          if (fb == 0 || mag(m) <= mag_t'(1) || mag(fb) < {1'b0, vtol}) begin
            phase     <= PH_IDLE;
            state     <= S_IDLE;
            out_valid <= 1'b1;
            out_data  <= '{status: ST_CONVERGED, point: bpt};
          end else if (estep == 0 || mag(fa) <= mag(fb)) begin
            dstep <= m;
            estep <= m;
            state <= S_UPD;
          end else begin
            state <= S_D1;
          end
        end
        S_D1: begin
          if (ursp.done) begin
            s     <= ursp.y;
            state <= coll ? S_M1 : S_D2;
          end
        end
        S_M1: begin
          if (ursp.done) begin
            p     <= ursp.y;
            state <= S_Q1;
          end
        end
        S_Q1: begin
          q     <= ssub(ONE, s);
          state <= S_SGN;
        end
        S_D2: begin
          if (ursp.done) begin
            q     <= ursp.y;
            state <= S_D3;
          end
        end
        S_D3: begin
          if (ursp.done) begin
            r     <= ursp.y;
            state <= S_M2;
          end
        end
        S_M2: begin
          if (ursp.done) begin
            t     <= ursp.y;
            state <= S_M3;
          end
        end
        S_M3: begin
          if (ursp.done) begin
            t     <= ursp.y;
            state <= S_M4;
          end
        end
        S_M4: begin
          if (ursp.done) begin
            u     <= ursp.y;
            state <= S_M5;
          end
        end
        S_M5: begin
          if (ursp.done) begin
            p     <= ursp.y;
            state <= S_M6;
          end
        end
        S_M6: begin
          if (ursp.done) begin
            t     <= ursp.y;
            state <= S_M7;
          end
        end
        S_M7: begin
          if (ursp.done) begin
            q     <= ursp.y;
            state <= S_SGN;
          end
        end
        S_SGN: begin
          if (p > 0) begin
            q <= ssub('0, q);
          end else begin
            p <= ssub('0, p);
          end
          state <= S_M8;
        end
        S_M8: begin
          if (ursp.done) begin
            t     <= ssub(ursp.y, val_t'(mag(q) >> FRAC_BITS));
            state <= S_M9;
          end
        end
        S_M9: begin
          if (ursp.done) begin
            u     <= sabs(ursp.y);
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (sadd(p, p) < ((t < u) ? t : u)) begin
            estep <= dstep;
            state <= S_D4;
          end else begin
            dstep <= m;
            estep <= m;
            state <= S_UPD;
          end
        end
        S_D4: begin
          if (ursp.done) begin
            dstep <= ursp.y;
            state <= S_UPD;
          end
        end
        S_UPD: begin
          apt       <= bpt;
          fa        <= fb;
          bpt       <= nb;
          phase     <= PH_STEP;
          state     <= S_IDLE;
          out_valid <= 1'b1;
          out_data  <= '{status: ST_EVAL, point: nb};
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_pending: assert property (@(posedge clk) disable iff (rst)
    ursp.done |-> pend)
    else $error("arithmetic unit result without a pending request");

  a_idle_phase: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (state == S_IDLE))
    else $error("sequencer busy with no search running");

  a_step_start: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_data.kind == KIND_ANSWER && phase == PH_STEP && iter < ilim)
    |=> (state == S_B1))
    else $error("answer under the iteration limit did not start a step");

endmodule

FILE: design/brs_alu.sv
// ----------------------------------------------------------------------------
// brs_alu
// Shared serial fixed-point unit: shift-add multiply and restoring divide,
// magnitude based, with saturation of the signed result.
// ----------------------------------------------------------------------------
module brs_alu #(
  parameter int FRAC_BITS = brs_pkg::FRACTION_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  brs_pkg::alu_req_t req,
  output brs_pkg::alu_rsp_t rsp
);
  import brs_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int DW = W + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_MUL  = 2'd1;
  localparam logic [1:0] U_DIV  = 2'd2;
  localparam logic [1:0] U_FIN  = 2'd3;

  logic [1:0]    ustate;
  logic [CW-1:0] cnt;
  logic          neg;
  logic          is_div;
  wide_t         acc;
  wide_t         mcand;
  mag_t          mplier;
  mag_t          dv;
  logic [W-1:0]  rem;
  logic [DW-1:0] dvd;
  logic [DW-1:0] quo;
  logic          done;
  val_t          y;

  logic [W:0]    rs;
  logic [W:0]    rdiff;
  logic          rge;
  wide_t         fin_mag;

  always_comb begin
    rs      = {rem, dvd[DW-1]};
    rdiff   = rs - {1'b0, dv};
    rge     = rs >= {1'b0, dv};
    fin_mag = is_div ? wide_t'(quo) : (acc >> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ustate <= U_IDLE;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (ustate)
        U_IDLE: begin
          if (req.start) begin
            neg    <= (req.a < 0) != (req.b < 0);
            is_div <= req.div;
            if (req.div) begin
              if (req.b == 0) begin
                y    <= (req.a > 0) ? VMAX : ((req.a < 0) ? VMIN : '0);
                done <= 1'b1;
              end else begin
                dv     <= mag(req.b);
                rem    <= '0;
                dvd    <= {mag(req.a), {FRAC_BITS{1'b0}}};
                quo    <= '0;
                cnt    <= CW'(DW);
                ustate <= U_DIV;
              end
            end else begin
              acc    <= '0;
              mcand  <= wide_t'(mag(req.a));
              mplier <= mag(req.b);
              cnt    <= CW'(W);
              ustate <= U_MUL;
            end
          end
        end
        U_MUL: begin
          if (mplier[0]) begin
            acc <= acc + mcand;
          end
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          cnt    <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            ustate <= U_FIN;
          end
        end
        U_DIV: begin
          rem    <= rge ? rdiff[W-1:0] : rs[W-1:0];
          quo    <= {quo[DW-2:0], rge};
          dvd    <= dvd << 1;
          cnt    <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            ustate <= U_FIN;
          end
        end
        U_FIN: begin
          y      <= from_mag(neg, fin_mag);
          done   <= 1'b1;
          ustate <= U_IDLE;
        end
        default: begin
          ustate <= U_IDLE;
        end
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.y    = y;

endmodule

FILE: tb/sv/brs_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_result_checker
// Watches the configuration, input and result channels of the Brent root
// solver, tracks the search state and register settings itself, predicts
// every result transaction and compares it field by field, in order.
// ----------------------------------------------------------------------------
module brs_result_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  brs_pkg::in_t                   in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  brs_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [brs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  brs_pkg::val_t                  cfg_data,
  output int                             fail_count,
  output int                             pending_count
);
  import brs_pkg::*;

  localparam longint VMAX_L = 64'sd2147483647;
  localparam longint VMIN_L = -VMAX_L - 1;
  localparam longint ONE_L  = 64'sd65536;
  localparam longint LSB_L  = 64'sd1;

  localparam logic [1:0] SRCH_IDLE = 2'd0;
  localparam logic [1:0] SRCH_LOW  = 2'd1;
  localparam logic [1:0] SRCH_HIGH = 2'd2;
  localparam logic [1:0] SRCH_STEP = 2'd3;

  longint lo_end, hi_end, tol_level;
  int unsigned iter_max, iter_done;
  logic [1:0] search_phase;
  longint target, b_pt, a_pt, c_pt, fb, fa, fc, d_step, e_step;
  logic collapsed;
  out_t expected_results[$];

  function automatic longint clip(longint x);
    if (x > VMAX_L) return VMAX_L;
    if (x < VMIN_L) return VMIN_L;
    return x;
  endfunction

  function automatic longint magn(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint from_magn(logic neg, longint m);
    if (m > (neg ? VMAX_L + 1 : VMAX_L)) return neg ? VMIN_L : VMAX_L;
    return neg ? -m : m;
  endfunction

  function automatic longint q_add(longint a, longint b);
    return clip(a + b);
  endfunction

  function automatic longint q_sub(longint a, longint b);
    return clip(a - b);
  endfunction

  function automatic longint q_abs(longint a);
    return from_magn(1'b0, magn(a));
  endfunction

  function automatic longint q_mul(longint a, longint b);
    return from_magn((a < 0) != (b < 0), (magn(a) * magn(b)) >>> 16);
  endfunction

  function automatic longint q_div(longint a, longint b);
    if (b == 0) return a > 0 ? VMAX_L : (a < 0 ? VMIN_L : 0);
    return from_magn((a < 0) != (b < 0), (magn(a) <<< 16) / magn(b));
  endfunction

  function automatic out_t make_result(logic [1:0] st, longint p);
    out_t o;
    o.status = st;
    o.point  = val_t'(p);
    return o;
  endfunction

  function automatic out_t brent_update();
    longint m, p, q, r, s, t, min1, min2;
    if ((fb < 0 && fc < 0) || (fb > 0 && fc > 0)) begin
      c_pt = a_pt;
      fc = fa;
      d_step = q_sub(b_pt, a_pt);
      e_step = d_step;
    end
    if (magn(fc) < magn(fb)) begin
      a_pt = b_pt; b_pt = c_pt; c_pt = a_pt;
      fa = fb; fb = fc; fc = fa;
    end
    collapsed = (a_pt == c_pt);
    m = clip((c_pt - b_pt) / 2);
    if (fb == 0 || magn(m) <= LSB_L || magn(fb) < tol_level) begin
      search_phase = SRCH_IDLE;
      return make_result(ST_CONVERGED, b_pt);
    end
    if (magn(e_step) < LSB_L || magn(fa) <= magn(fb)) begin
      d_step = m; e_step = m;
    end else begin
      s = q_div(fb, fa);
      if (collapsed) begin
        p = q_mul(q_add(m, m), s);
        q = q_sub(ONE_L, s);
      end else begin
        q = q_div(fa, fc);
        r = q_div(fb, fc);
        t = q_mul(q_mul(q_add(m, m), q), q_sub(q, r));
        p = q_mul(s, q_sub(t, q_mul(q_sub(b_pt, a_pt), q_sub(r, ONE_L))));
        q = q_mul(q_mul(q_sub(q, ONE_L), q_sub(r, ONE_L)), q_sub(s, ONE_L));
      end
      if (p > 0) q = q_sub(0, q);
      else p = q_sub(0, p);
      min1 = q_sub(q_mul(q_add(q_add(m, m), m), q), q_abs(q_mul(LSB_L, q)));
      min2 = q_abs(q_mul(e_step, q));
      if (q_add(p, p) < (min1 < min2 ? min1 : min2)) begin
        e_step = d_step;
        d_step = q_div(p, q);
      end else begin
        d_step = m; e_step = m;
      end
    end
    a_pt = b_pt;
    fa = fb;
    if (magn(d_step) > LSB_L) b_pt = q_add(b_pt, d_step);
    else b_pt = q_add(b_pt, m > 0 ? LSB_L : -LSB_L);
    search_phase = SRCH_STEP;
    return make_result(ST_EVAL, b_pt);
  endfunction

  task automatic predict_item(in_t x);
    longint f;
    if (x.kind == KIND_START) begin
      target = longint'(x.reference_level);
      a_pt = lo_end;
      b_pt = hi_end;
      search_phase = SRCH_LOW;
      expected_results.push_back(make_result(ST_EVAL, a_pt));
    end else if (search_phase != SRCH_IDLE) begin
      f = q_sub(longint'(x.function_value), target);
      if (search_phase == SRCH_LOW) begin
        fa = f;
        search_phase = SRCH_HIGH;
        expected_results.push_back(make_result(ST_EVAL, b_pt));
      end else begin
        fb = f;
        if (search_phase == SRCH_HIGH) begin
          if ((f > 0 && fa > 0) || (f < 0 && fa < 0)) begin
            search_phase = SRCH_IDLE;
            expected_results.push_back(make_result(ST_NO_ROOT, ONE_L));
          end else begin
            fc = f;
            c_pt = 0; d_step = 0; e_step = 0;
            collapsed = 1'b0;
            iter_done = 0;
            expected_results.push_back(brent_update());
          end
        end else if (iter_done >= iter_max) begin
          search_phase = SRCH_IDLE;
          expected_results.push_back(make_result(ST_LIMIT, b_pt));
        end else begin
          iter_done = iter_done + 1;
          expected_results.push_back(brent_update());
        end
      end
    end
  endtask

  task automatic compare_result(out_t got);
    out_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result transaction: status %0d point %0d", got.status, got.point);
      fail_count = fail_count + 1;
    end else begin
      want = expected_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        fail_count = fail_count + 1;
      end
      if (got.point !== want.point) begin
        $error("point: expected %0d, actual %0d", want.point, got.point);
        fail_count = fail_count + 1;
      end
    end
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      lo_end = 0; hi_end = ONE_L; iter_max = 100; tol_level = 0;
      search_phase = SRCH_IDLE;
      target = 0; b_pt = 0; a_pt = 0; c_pt = 0; fb = 0; fa = 0; fc = 0;
      d_step = 0; e_step = 0; collapsed = 1'b0; iter_done = 0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) compare_result(out_data);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_INTERVAL_LOW:  lo_end = longint'(cfg_data);
          CFG_INTERVAL_HIGH: hi_end = longint'(cfg_data);
          CFG_ITER_LIMIT:    iter_max = cfg_data[15:0];
          CFG_VALUE_TOL:     tol_level = longint'({33'd0, cfg_data[30:0]});
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_item(in_data);
    end
    pending_count <= expected_results.size();
  end

endmodule

FILE: tb/sv/brent_root_solver_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brent_root_solver_core_test
// Plays the outside function for the Brent root solver: starts searches,
// answers each requested point from a chosen function shape, mixes in noise,
// restarts and ignored answers, and sweeps interval, limit and tolerance
// settings under varying idle and stall patterns. A checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module brent_root_solver_core_test;
  import brs_pkg::*;

  localparam int  CYCLE_LIMIT = 3000000;
  localparam int  SETTLE      = 600;
  localparam int  ITEM_GOAL   = 650;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  in_t  in_data;
  out_t out_data;
  logic [CFG_IDX_W-1:0] cfg_index;
  val_t cfg_data;
  int fail_count, pending_count;

  int tx_pct, rx_pct, cycles, items, searches;
  logic rx_hold;
  out_t last_res;
  int res_count, res_seen;
  int status_seen[4];
  longint cur_lo, cur_hi;

  brent_root_solver_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  brs_result_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    out_stall <= rx_hold || ($urandom_range(0, 99) < rx_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      last_res <= out_data;
      res_count <= res_count + 1;
      status_seen[out_data.status] <= status_seen[out_data.status] + 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("brent_root_solver_core test failed");
      $finish;
    end
  end

  task automatic push_item(in_t it);
    if ($urandom_range(0, 99) < tx_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    items++;
  endtask

  task automatic send_start(longint lvl);
    in_t it;
    it.kind = KIND_START;
    it.reference_level = val_t'(lvl);
    it.function_value = val_t'($urandom);
    push_item(it);
  endtask

  task automatic send_answer(longint v);
    in_t it;
    it.kind = KIND_ANSWER;
    it.reference_level = val_t'($urandom);
    it.function_value = val_t'(v);
    push_item(it);
  endtask

  task automatic wait_result(output out_t r);
    in_valid <= 1'b0;
    while (res_seen == res_count) @(posedge clk);
    res_seen = res_count;
    r = last_res;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    res_seen = res_count;
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, longint v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val_t'(v);
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
  endtask

  task automatic configure(longint lo, longint hi, longint lim, longint tol);
    settle();
    cfg_write(CFG_INTERVAL_LOW, lo);
    cfg_write(CFG_INTERVAL_HIGH, hi);
    cfg_write(CFG_ITER_LIMIT, lim);
    cfg_write(CFG_VALUE_TOL, tol);
    cfg_valid <= 1'b0;
    cur_lo = longint'(val_t'(lo));
    cur_hi = longint'(val_t'(hi));
  endtask

  function automatic longint sample_fn(int shape, longint x, longint root, longint k,
                                       longint lvl);
    longint d, t, v;
    d = x - root;
    case (shape)
      0: v = (d * k) >>> 16;
      1: begin
        t = d >>> 8;
        v = (((t * t) >>> 16) * t) >>> 8;
      end
      2: v = d > 0 ? k : (d < 0 ? -k : 0);
      default: v = longint'(val_t'($urandom));
    endcase
    if ($urandom_range(0, 19) == 0) v = longint'(val_t'($urandom));
    v = v + lvl;
    if (v > longint'(VMAX)) v = longint'(VMAX);
    if (v < longint'(VMIN)) v = longint'(VMIN);
    return v;
  endfunction

  // returns 1 when the search ran to a final status
  task automatic run_search(int shape, int max_answers, output bit finished);
    longint root, k, lvl, span;
    out_t r;
    int n;
    lvl = longint'(val_t'($urandom));
    if ($urandom_range(0, 3) == 0) lvl = $urandom_range(0, 1) ? longint'(VMAX) : longint'(VMIN);
    span = cur_hi > cur_lo ? cur_hi - cur_lo + 1 : 64'sd65536;
    root = (cur_hi > cur_lo ? cur_lo : cur_hi) + longint'({$urandom, $urandom} % span);
    if ($urandom_range(0, 7) == 0) root = root + span;
    k = longint'($urandom_range(1, 32'h40000));
    if (shape == 2) k = longint'($urandom_range(1, 32'h7fffffff));
    if ($urandom_range(0, 1)) k = -k;
    searches++;
    finished = 1'b0;
    send_start(lvl);
    wait_result(r);
    n = 0;
    while (r.status == ST_EVAL) begin
      if (n >= max_answers) return;
      n++;
      send_answer(sample_fn(shape, longint'(r.point), root, k, lvl));
      wait_result(r);
    end
    finished = 1'b1;
  endtask

  task automatic random_setting();
    case ($urandom_range(0, 5))
      0: configure(-10 * 65536, 10 * 65536, 100, 0);
      1: configure(longint'(val_t'($urandom)), longint'(val_t'($urandom)),
                   $urandom_range(0, 20), $urandom_range(0, 4096));
      2: configure(longint'(VMIN), longint'(VMAX), 65535, 0);
      3: configure(0, 65536, 0, 32'h7fffffff);
      4: configure(-1, 1, 5, 0);
      default: configure(longint'(val_t'($urandom)), longint'(val_t'($urandom)),
                         100, $urandom_range(0, 32'h7fffffff));
    endcase
  endtask

  initial begin
    out_t r;
    bit done;
    int stage, goal;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rx_hold = 1'b0;
    tx_pct = 0;
    rx_pct = 0;
    cycles = 0;
    items = 0;
    searches = 0;
    res_count = 0;
    res_seen = 0;
    last_res = '0;
    cur_lo = 0;
    cur_hi = 65536;
    for (int i = 0; i < 4; i++) status_seen[i] = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // answer with no search running, then full-scale levels and a restart
    send_answer(longint'(VMAX));
    send_start(longint'(VMIN));
    wait_result(r);
    send_answer(longint'(VMIN));
    wait_result(r);
    send_answer(longint'(VMAX));
    wait_result(r);
    send_start(longint'(VMAX));
    wait_result(r);
    send_answer(0);
    wait_result(r);
    send_answer(0);
    wait_result(r);
    // exact root at the upper end
    send_start(0);
    wait_result(r);
    send_answer(-5 * 65536);
    wait_result(r);
    send_answer(0);
    wait_result(r);
    // zero iteration limit
    configure(0, 65536, 0, 0);
    send_start(0);
    wait_result(r);
    send_answer(-65536);
    wait_result(r);
    send_answer(65536);
    wait_result(r);
    send_answer(20000);
    wait_result(r);
    // widest tolerance accepts at once
    configure(longint'(VMIN), longint'(VMAX), 65535, 32'h7fffffff);
    send_start(0);
    wait_result(r);
    send_answer(-65536);
    wait_result(r);
    send_answer(65536);
    wait_result(r);

    // long receiver hold while starts keep coming
    configure(-10 * 65536, 10 * 65536, 100, 0);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (400) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    for (int i = 0; i < 8; i++) send_start(longint'(val_t'($urandom)));
    settle();

    for (stage = 0; stage < 3; stage++) begin
      tx_pct = stage == 0 ? 8 : (stage == 1 ? 88 : 0);
      rx_pct = stage == 0 ? 88 : (stage == 1 ? 8 : 0);
      goal = (ITEM_GOAL * (stage + 1)) / 3;
      while (items < goal) begin
        random_setting();
        for (int j = 0; j < 4 && items < goal; j++) begin
          run_search($urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2),
                     $urandom_range(0, 7) == 0 ? $urandom_range(0, 3) : 40, done);
          if (done && $urandom_range(0, 5) == 0) send_answer(longint'(val_t'($urandom)));
        end
      end
    end

    settle();
    $display("%0d input transactions over %0d searches under swept interval, limit and", items,
             searches);
    $display("tolerance settings; results: %0d eval, %0d converged, %0d no root, %0d limit",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (fail_count == 0 && pending_count == 0) begin
      $display("brent_root_solver_core test passed");
    end else begin
      $display("brent_root_solver_core test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/brs_pkg.sv
design/brs_alu.sv
design/brent_root_solver_core.sv
tb/sv/brs_result_checker.sv
tb/sv/brent_root_solver_core_test.sv
